@@ hw/rtl/zstring_text_decoder_assert.svh @@
// Assertion macros for the packed text decoder.
// Clocked on clk_i, disabled while rst_ni is low; used by the top level only.
`ifndef ZSTRING_TEXT_DECODER_ASSERT_SVH
`define ZSTRING_TEXT_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ZTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ZTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ztd_pkg.sv @@
// Package for the packed text decoder: widths, result codes, queue entry types
// and the alphabet lookup functions. No dependencies.
package ztd_pkg;

  localparam int unsigned WORD_W          = 16;
  localparam int unsigned DEPTH_W         = 2;
  localparam int unsigned NUM_LEVELS      = 4;
  localparam int unsigned MAX_DEPTH       = 3;
  localparam int unsigned MAX_BUFFER      = 4096;
  localparam int unsigned CNT_W           = 13;
  localparam int unsigned CODE_W          = 8;
  localparam int unsigned ADDR_W          = 17;
  localparam int unsigned BASE_W          = 16;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned ZCHAR_W         = 5;
  localparam int unsigned ZCHARS_PER_WORD = 3;
  localparam int unsigned MAX_RESULTS     = 4;
  localparam int unsigned RES_IDX_W       = 2;
  localparam int unsigned RES_CNT_W       = 3;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = 2;
  localparam int unsigned QCNT_W          = 3;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABBREV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ABBREV_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS   = 1'b1;

  localparam logic [1:0] ALPHA_A0 = 2'd0;
  localparam logic [1:0] ALPHA_A1 = 2'd1;
  localparam logic [1:0] ALPHA_A2 = 2'd2;

  localparam logic [ZCHAR_W-1:0] ZC_SPACE   = 5'd0;
  localparam logic [ZCHAR_W-1:0] ZC_ABB_MAX = 5'd3;
  localparam logic [ZCHAR_W-1:0] ZC_SHF_MAX = 5'd5;
  localparam logic [ZCHAR_W-1:0] ZC_LITERAL = 5'd6;

  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0]         shift_alpha;
    logic               shift_active;
    logic               abbrev_pending;
    logic [1:0]         abbrev_bank;
    logic               literal_pending;
    logic               literal_stage;
    logic [ZCHAR_W-1:0] literal_high;
  } ztd_level_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] char_code;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } ztd_result_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]               n;
    ztd_result_t [MAX_RESULTS-1:0]      res;
  } ztd_entry_t;

  typedef struct packed {
    logic       valid;
    ztd_entry_t entry;
  } ztd_qport_t;

  // A0 and A1: letters starting at z-char 6
  function automatic logic [CODE_W-1:0] alpha_letter(input logic [ZCHAR_W-1:0] zc,
                                                     input logic upper);
    logic [CODE_W-1:0] base;
    base = upper ? 8'h41 : 8'h61;
    return base + {3'b000, zc} - 8'd6;
  endfunction

  // A2 punctuation row
  function automatic logic [CODE_W-1:0] alpha_punct(input logic [ZCHAR_W-1:0] zc);
    logic [CODE_W-1:0] c;
    unique case (zc)
      5'd7:  c = 8'h0A;
      5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17: c = 8'h30 + {3'b000, zc} - 8'd8;
      5'd18: c = 8'h2E;
      5'd19: c = 8'h2C;
      5'd20: c = 8'h21;
      5'd21: c = 8'h3F;
      5'd22: c = 8'h5F;
      5'd23: c = 8'h23;
      5'd24: c = 8'h27;
      5'd25: c = 8'h22;
      5'd26: c = 8'h2F;
      5'd27: c = 8'h5C;
      5'd28: c = 8'h2D;
      5'd29: c = 8'h3A;
      5'd30: c = 8'h28;
      5'd31: c = 8'h29;
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/ztd_in_if.sv @@
// Input channel of the packed text decoder: valid/ready plus word payload.
// Depends on ztd_pkg.
interface ztd_in_if;
  import ztd_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   word;
  logic [DEPTH_W-1:0]  depth;
  logic                first_word;

  modport source (output valid, word, depth, first_word, input ready);
  modport sink   (input valid, word, depth, first_word, output ready);
endinterface

@@ hw/rtl/ztd_out_if.sv @@
// Result channel of the packed text decoder: valid/ready plus result payload.
// Depends on ztd_pkg.
interface ztd_out_if;
  import ztd_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CODE_W-1:0]   char_code;
  logic [ADDR_W-1:0]   abbrev_entry_addr;
  logic [CNT_W-1:0]    char_count;
  logic                last;

  modport source (output valid, kind, char_code, abbrev_entry_addr, char_count, last,
                  input ready);
  modport sink   (input valid, kind, char_code, abbrev_entry_addr, char_count, last,
                  output ready);
endinterface

@@ hw/rtl/ztd_front.sv @@
// Front end: accepts words, keeps per-depth decode state and the shared count,
// and builds one queue entry of up to four results per word. Uses ztd_pkg, ztd_in_if.
module ztd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ztd_in_if.sink                        in_i,
  input  logic                          cfg_we_i,
  input  logic [ztd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ztd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          q_full_i,
  output ztd_pkg::ztd_qport_t           push_o
);
  import ztd_pkg::*;

  ztd_level_t [NUM_LEVELS-1:0] level_q, level_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              done_q, done_d;
  logic [BASE_W-1:0] abbrev_base_q;
  logic [CNT_W-1:0]  usable_q;

  logic        accept;
  ztd_entry_t  entry;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    ztd_level_t         lvl;
    logic [CNT_W-1:0]   cnt_base;
    logic               done_base;
    logic [CNT_W-1:0]   diff;
    logic [2:0]         room;
    logic [1:0]         taken;
    logic [ZCHAR_W-1:0] zc;
    logic               emit_char;
    logic               emit_req;
    logic [CODE_W-1:0]  char_val;
    logic [1:0]         alpha;
    logic               fin;
    logic               clear_all;

    clear_all = in_i.first_word && (in_i.depth == '0);
    lvl       = in_i.first_word ? '0 : level_q[in_i.depth];
    cnt_base  = clear_all ? '0 : out_count_q;
    done_base = clear_all ? 1'b0 : done_q;

    diff = usable_q - cnt_base;
    if (cnt_base >= usable_q) begin
      room = 3'd0;
    end else if (diff > CNT_W'(4)) begin
      room = 3'd4;
    end else begin
      room = diff[2:0];
    end

    taken = '0;
    entry = '0;

    for (int i = 0; i < ZCHARS_PER_WORD; i++) begin
      zc        = in_i.word[(ZCHARS_PER_WORD - 1 - i) * ZCHAR_W +: ZCHAR_W];
      emit_char = 1'b0;
      emit_req  = 1'b0;
      char_val  = '0;
      alpha     = ALPHA_A0;
      if (lvl.literal_pending) begin
        if (!lvl.literal_stage) begin
          lvl.literal_high  = zc;
          lvl.literal_stage = 1'b1;
        end else begin
          emit_char           = 1'b1;
          char_val            = {lvl.literal_high[2:0], zc};
          lvl.literal_pending = 1'b0;
          lvl.literal_stage   = 1'b0;
        end
      end else if (lvl.abbrev_pending) begin
        emit_req           = (in_i.depth < DEPTH_W'(MAX_DEPTH)) && ({1'b0, taken} < room);
        lvl.abbrev_pending = 1'b0;
      end else if (zc == ZC_SPACE) begin
        emit_char        = 1'b1;
        char_val         = CHAR_SPACE;
        lvl.shift_active = 1'b0;
      end else if (zc <= ZC_ABB_MAX) begin
        lvl.abbrev_pending = 1'b1;
        lvl.abbrev_bank    = zc[1:0];
        lvl.shift_active   = 1'b0;
      end else if (zc <= ZC_SHF_MAX) begin
        lvl.shift_alpha  = 2'(zc - 5'd3);
        lvl.shift_active = 1'b1;
      end else begin
        alpha            = lvl.shift_active ? lvl.shift_alpha : ALPHA_A0;
        lvl.shift_active = 1'b0;
        if (alpha == ALPHA_A2 && zc == ZC_LITERAL) begin
          lvl.literal_pending = 1'b1;
          lvl.literal_stage   = 1'b0;
        end else if (alpha == ALPHA_A2) begin
          emit_char = 1'b1;
          char_val  = alpha_punct(zc);
        end else begin
          emit_char = 1'b1;
          char_val  = alpha_letter(zc, alpha == ALPHA_A1);
        end
      end

      if (emit_char && ({1'b0, taken} < room)) begin
        taken                               = taken + 2'd1;
        entry.res[entry.n[RES_IDX_W-1:0]].kind      = KIND_CHAR;
        entry.res[entry.n[RES_IDX_W-1:0]].char_code = char_val;
        entry.res[entry.n[RES_IDX_W-1:0]].count     = cnt_base + CNT_W'(taken);
        entry.n                             = entry.n + RES_CNT_W'(1);
      end
      if (emit_req) begin
        entry.res[entry.n[RES_IDX_W-1:0]].kind  = KIND_ABBREV;
        entry.res[entry.n[RES_IDX_W-1:0]].addr  =
          ADDR_W'(abbrev_base_q) + ADDR_W'({2'(lvl.abbrev_bank - 2'd1), zc, 1'b0});
        entry.res[entry.n[RES_IDX_W-1:0]].count = cnt_base + CNT_W'(taken);
        entry.n                                 = entry.n + RES_CNT_W'(1);
      end
    end

    fin = !done_base &&
          (((in_i.depth == '0) && in_i.word[WORD_W-1]) || ({1'b0, taken} >= room));
    if (fin) begin
      entry.res[entry.n[RES_IDX_W-1:0]].kind  = KIND_END;
      entry.res[entry.n[RES_IDX_W-1:0]].count = cnt_base + CNT_W'(taken);
      entry.n                                 = entry.n + RES_CNT_W'(1);
    end

    level_d     = level_q;
    out_count_d = out_count_q;
    done_d      = done_q;
    if (accept) begin
      if (clear_all) begin
        level_d = '0;
      end
      level_d[in_i.depth] = lvl;
      out_count_d         = cnt_base + CNT_W'(taken);
      done_d              = done_base || fin;
    end
  end

  assign push_o.valid = accept && (entry.n != '0);
  assign push_o.entry = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      out_count_q <= '0;
      done_q      <= 1'b0;
    end else begin
      level_q     <= level_d;
      out_count_q <= out_count_d;
      done_q      <= done_d;
    end
  end

  // max_chars is kept as the number of usable slots, clamped to the buffer size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abbrev_base_q <= '0;
      usable_q      <= CNT_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ABBREV_BASE: abbrev_base_q <= cfg_wdata_i[BASE_W-1:0];
        REG_MAX_CHARS: begin
          if (cfg_wdata_i[CNT_W-1:0] == '0) begin
            usable_q <= '0;
          end else if (cfg_wdata_i[CNT_W-1:0] > CNT_W'(MAX_BUFFER)) begin
            usable_q <= CNT_W'(MAX_BUFFER - 1);
          end else begin
            usable_q <= cfg_wdata_i[CNT_W-1:0] - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/ztd_queue.sv @@
// Short queue of decoded word entries between front and back end.
// Depends on ztd_pkg.
module ztd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ztd_pkg::ztd_qport_t push_i,
  output logic                full_o,
  output ztd_pkg::ztd_qport_t head_o,
  input  logic                pop_i
);
  import ztd_pkg::*;

  ztd_entry_t               slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]        count_q, count_d;
  logic                     do_push, do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

@@ hw/rtl/ztd_back.sv @@
// Back end: walks the results of the head queue entry, one transfer per cycle while out_o is ready.
// Depends on ztd_pkg and ztd_out_if.
module ztd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ztd_pkg::ztd_qport_t head_i,
  output logic                pop_o,
  ztd_out_if.source           out_o
);
  import ztd_pkg::*;

  logic [RES_IDX_W-1:0] idx_q, idx_d;
  ztd_result_t          cur;
  logic                 is_last;
  logic                 xfer;

  assign cur     = head_i.entry.res[idx_q];
  assign is_last = (RES_CNT_W'(idx_q) + RES_CNT_W'(1)) == head_i.entry.n;
  assign xfer    = out_o.valid && out_o.ready;
  assign pop_o   = xfer && is_last;

  assign out_o.valid             = head_i.valid;
  assign out_o.kind              = cur.kind;
  assign out_o.char_code         = cur.char_code;
  assign out_o.abbrev_entry_addr = cur.addr;
  assign out_o.char_count        = cur.count;
  assign out_o.last              = is_last;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = is_last ? '0 : idx_q + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ hw/rtl/zstring_text_decoder.sv @@
// Packed text decoder: each accepted 16-bit word yields up to four results
// (characters, abbreviation fetch requests, end marker), delivered one transfer
// per cycle while out_o is ready. A word is taken whenever the four-entry queue
// between the decoder and the output stage has room, so new words can be taken
// while earlier results still wait for the single-result output port. A queued
// word carries 1 to 4 results (three characters plus end at most).
// Words that produce no result never reach the queue.
// Uses ztd_pkg, ztd_in_if, ztd_out_if, ztd_front, ztd_queue, ztd_back and the
// assertion macros in zstring_text_decoder_assert.svh.
`include "zstring_text_decoder_assert.svh"

module zstring_text_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ztd_in_if.sink                         in_i,
  ztd_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ztd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ztd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ztd_pkg::*;

  ztd_qport_t push;
  ztd_qport_t head;
  logic       q_full;
  logic       pop;

  ztd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  ztd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ztd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  `ZTD_ASSERT_NOW(a_head_nonempty, head.valid, head.entry.n != '0, "queued entry without results")
  `ZTD_ASSERT_NEXT(a_more_follow, out_o.valid && out_o.ready && !out_o.last, out_o.valid, "entry ended early")
  `ZTD_ASSERT_NOW(a_end_clean, out_o.valid && out_o.kind == KIND_END, out_o.char_code == '0 && out_o.abbrev_entry_addr == '0, "end result carries payload")
  `ZTD_ASSERT_NOW(a_push_room, push.valid, !q_full, "push into full queue")

endmodule

@@ dv/zstring_text_decoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for zstring_text_decoder: directed and random packed text words,
// nested abbreviation expansions and size settings, every result transfer checked in order.
// Depends on ztd_pkg, ztd_in_if, ztd_out_if and the decoder RTL.
module zstring_text_decoder_tb;
  import ztd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 380;
  localparam logic [ZCHAR_W-1:0] ZC_BANK1    = 5'd1;
  localparam logic [ZCHAR_W-1:0] ZC_BANK2    = 5'd2;
  localparam logic [ZCHAR_W-1:0] ZC_BANK3    = ZC_ABB_MAX;
  localparam logic [ZCHAR_W-1:0] ZC_SHIFT_A1 = ZC_ABB_MAX + 5'd1;
  localparam logic [ZCHAR_W-1:0] ZC_SHIFT_A2 = ZC_SHF_MAX;
  localparam logic [ZCHAR_W-1:0] ZC_TOP      = 5'd31;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [DEPTH_W-1:0] depth;
    logic               first_word;
  } text_word_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] char_code;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic              last;
  } decoded_t;

  string row_a0 = "abcdefghijklmnopqrstuvwxyz";
  string row_a1 = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string row_a2 = " \n0123456789.,!?_#'\"/\\-:()";

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = REG_ABBREV_BASE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  send_valid = 1'b0;
  logic [WORD_W-1:0]     send_word  = '0;
  logic [DEPTH_W-1:0]    send_depth = '0;
  logic                  send_first = 1'b0;
  logic                  take_ready = 1'b0;

  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned idle_pct = 0;
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned queued = 0;

  text_word_t pending_words[$];
  decoded_t   results_due[$];
  decoded_t   word_results[$];

  // predictor state
  ztd_level_t        lvl[NUM_LEVELS];
  logic [CNT_W-1:0]  chars_out;
  logic              ended;
  logic [BASE_W-1:0] base_reg;
  logic [CNT_W-1:0]  size_reg;

  ztd_in_if  text_in ();
  ztd_out_if text_out ();

  assign text_in.valid      = send_valid;
  assign text_in.word       = send_word;
  assign text_in.depth      = send_depth;
  assign text_in.first_word = send_first;
  assign text_out.ready     = take_ready;

  zstring_text_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (text_in),
    .out_o       (text_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned free_slots();
    int unsigned m;
    m = size_reg;
    if (m > MAX_BUFFER) m = MAX_BUFFER;
    if (m < 1) m = 1;
    return m - 1;
  endfunction

  function automatic void add_result(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                     logic [ADDR_W-1:0] addr);
    decoded_t r;
    r.kind      = kind;
    r.char_code = code;
    r.addr      = addr;
    r.count     = chars_out;
    r.last      = 1'b0;
    word_results.push_back(r);
  endfunction

  function automatic void add_char(logic [CODE_W-1:0] code);
    if (chars_out < free_slots()) begin
      chars_out++;
      add_result(KIND_CHAR, code, '0);
    end
  endfunction

  function automatic void decode_word(text_word_t t);
    logic [ZCHAR_W-1:0] zc;
    logic [1:0]         alpha;
    int                 d;
    int                 i;
    int                 off;
    d = t.depth;
    word_results.delete();
    if (t.first_word) begin
      if (d == 0) begin
        foreach (lvl[k]) lvl[k] = '0;
        chars_out = '0;
        ended = 1'b0;
      end else begin
        lvl[d] = '0;
      end
    end
    for (i = 0; i < ZCHARS_PER_WORD; i++) begin
      zc = t.word[14-5*i -: 5];
      if (lvl[d].literal_pending) begin
        if (!lvl[d].literal_stage) begin
          lvl[d].literal_high  = zc;
          lvl[d].literal_stage = 1'b1;
        end else begin
          add_char({lvl[d].literal_high[2:0], zc});
          lvl[d].literal_pending = 1'b0;
          lvl[d].literal_stage   = 1'b0;
        end
      end else if (lvl[d].abbrev_pending) begin
        if (d < MAX_DEPTH && chars_out < free_slots()) begin
          off = 2 * (32 * (int'(lvl[d].abbrev_bank) - 1) + int'(zc));
          add_result(KIND_ABBREV, '0, ADDR_W'(int'(base_reg) + off));
        end
        lvl[d].abbrev_pending = 1'b0;
      end else if (zc == ZC_SPACE) begin
        add_char(CHAR_SPACE);
        lvl[d].shift_active = 1'b0;
      end else if (zc <= ZC_ABB_MAX) begin
        lvl[d].abbrev_pending = 1'b1;
        lvl[d].abbrev_bank    = zc[1:0];
        lvl[d].shift_active   = 1'b0;
      end else if (zc <= ZC_SHF_MAX) begin
        lvl[d].shift_alpha  = 2'(int'(zc) - 3);
        lvl[d].shift_active = 1'b1;
      end else begin
        alpha = lvl[d].shift_active ? lvl[d].shift_alpha : ALPHA_A0;
        lvl[d].shift_active = 1'b0;
        if (alpha == ALPHA_A2 && zc == ZC_LITERAL) begin
          lvl[d].literal_pending = 1'b1;
          lvl[d].literal_stage   = 1'b0;
        end else if (alpha == ALPHA_A2) begin
          add_char(row_a2[int'(zc) - 6]);
        end else if (alpha == ALPHA_A1) begin
          add_char(row_a1[int'(zc) - 6]);
        end else begin
          add_char(row_a0[int'(zc) - 6]);
        end
      end
    end
    if (!ended && ((d == 0 && t.word[15]) || chars_out >= free_slots())) begin
      add_result(KIND_END, '0, '0);
      ended = 1'b1;
    end
    if (word_results.size() > 0) word_results[word_results.size()-1].last = 1'b1;
    foreach (word_results[k]) results_due.push_back(word_results[k]);
  endfunction

  function automatic void queue_word(input logic [ZCHAR_W-1:0] z0, z1, z2, input logic stop,
                                     input int d, input logic fw);
    text_word_t t;
    t.word       = {stop, z0, z1, z2};
    t.depth      = DEPTH_W'(d);
    t.first_word = fw;
    pending_words.push_back(t);
    queued++;
  endfunction

  // one string as a z-char stream; abbreviations get their expansion queued one level
  // down right after the word that carries the index
  function automatic void queue_string(input int d, input int tokens, input logic fw,
                                       input logic stop);
    logic [ZCHAR_W-1:0] zs[$];
    int                 fetch_word[$];
    int                 r;
    int                 n;
    int                 w;
    repeat (tokens) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        zs.push_back(ZC_SPACE);
      end else if (r < 22) begin
        zs.push_back(5'($urandom_range(ZC_BANK1, ZC_BANK3)));
        zs.push_back(5'($urandom_range(0, ZC_TOP)));
        fetch_word.push_back((zs.size() - 1) / 3);
      end else if (r < 36) begin
        if ($urandom_range(0, 1)) begin
          zs.push_back(ZC_SHIFT_A1);
          zs.push_back(5'($urandom_range(ZC_LITERAL, ZC_TOP)));
        end else begin
          zs.push_back(ZC_SHIFT_A2);
          zs.push_back(5'($urandom_range(ZC_LITERAL + 1, ZC_TOP)));
        end
      end else if (r < 46) begin
        zs.push_back(ZC_SHIFT_A2);
        zs.push_back(ZC_LITERAL);
        zs.push_back(5'($urandom_range(0, ZC_TOP)));
        zs.push_back(5'($urandom_range(0, ZC_TOP)));
      end else if (r < 50) begin
        zs.push_back(5'($urandom_range(ZC_SHIFT_A1, ZC_SHIFT_A2)));
      end else begin
        zs.push_back(5'($urandom_range(ZC_LITERAL, ZC_TOP)));
      end
    end
    while (zs.size() % 3 != 0) zs.push_back(ZC_SHIFT_A2);
    n = zs.size() / 3;
    for (w = 0; w < n; w++) begin
      queue_word(zs[3*w], zs[3*w+1], zs[3*w+2], stop && (w == n - 1), d, fw && (w == 0));
      foreach (fetch_word[k])
        if (fetch_word[k] == w && d < MAX_DEPTH)
          queue_string(d + 1, $urandom_range(1, 4), 1'b1, 1'b1);
    end
  endfunction

  task automatic apply_settings(input logic [BASE_W-1:0] base, input logic [CFG_DATA_W-1:0] size);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ABBREV_BASE;
    cfg_wdata <= base;
    @(posedge clk_i);
    cfg_idx   <= REG_MAX_CHARS;
    cfg_wdata <= size;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    base_reg = base;
    size_reg = size[CNT_W-1:0];
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || send_valid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0: idle_pct = 0;
      1: idle_pct = 8;
      default: idle_pct = 25;
    endcase
  endtask

  // word source and result sink
  always @(posedge clk_i) begin : drive_proc
    text_word_t nxt;
    if (!rst_ni) begin
      send_valid <= 1'b0;
      take_ready <= 1'b0;
    end else begin
      if (!send_valid || text_in.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          send_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          send_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 6);
          send_valid <= 1'b0;
        end else begin
          nxt = pending_words.pop_front();
          send_valid <= 1'b1;
          send_word  <= nxt.word;
          send_depth <= nxt.depth;
          send_first <= nxt.first_word;
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        take_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        take_gap = $urandom_range(0, 6);
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  // prediction on each accepted word, then the result check, in one process
  always @(posedge clk_i) begin : watch_proc
    text_word_t seen;
    decoded_t   want;
    if (rst_ni) begin
      if (text_in.valid && text_in.ready) begin
        seen.word       = text_in.word;
        seen.depth      = text_in.depth;
        seen.first_word = text_in.first_word;
        decode_word(seen);
      end
      if (text_out.valid && text_out.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected transfer: kind %0d char_code %0h char_count %0d",
                 text_out.kind, text_out.char_code, text_out.char_count);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (text_out.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, text_out.kind);
            mismatches++;
          end
          if (text_out.char_code !== want.char_code) begin
            $error("char_code: expected %0h, got %0h", want.char_code, text_out.char_code);
            mismatches++;
          end
          if (text_out.abbrev_entry_addr !== want.addr) begin
            $error("abbrev_entry_addr: expected %0h, got %0h", want.addr,
                   text_out.abbrev_entry_addr);
            mismatches++;
          end
          if (text_out.char_count !== want.count) begin
            $error("char_count: expected %0d, got %0d", want.count, text_out.char_count);
            mismatches++;
          end
          if (text_out.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, text_out.last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("zstring_text_decoder regression: fail");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned start;
    int unsigned target;
    int unsigned phase;
    int          r;
    logic [WORD_W-1:0] w;
    base_reg = '0;
    size_reg = 13'd256;
    foreach (lvl[k]) lvl[k] = '0;
    chars_out = '0;
    ended = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: alphabets, shifts, literals, requests, depth limit
    idle_pct = 8;
    queue_word(5'd6, 5'd7, 5'd8, 1'b0, 0, 1'b1);
    queue_word(ZC_SHIFT_A1, 5'd6, ZC_SHIFT_A2, 1'b0, 0, 1'b0);
    queue_word(5'd7, ZC_SPACE, ZC_SHIFT_A1, 1'b0, 0, 1'b0);
    queue_word(ZC_SPACE, 5'd6, ZC_TOP, 1'b0, 0, 1'b0);
    queue_word(ZC_SHIFT_A2, ZC_LITERAL, 5'd3, 1'b0, 0, 1'b0);
    queue_word(ZC_TOP, ZC_BANK1, ZC_SPACE, 1'b0, 0, 1'b0);
    queue_word(ZC_BANK2, ZC_TOP, 5'd6, 1'b1, 1, 1'b1);
    queue_word(ZC_BANK3, ZC_TOP, ZC_SHIFT_A2, 1'b1, 2, 1'b1);
    queue_word(ZC_BANK1, ZC_SHIFT_A2, ZC_SPACE, 1'b1, 3, 1'b1);
    queue_word(ZC_SHIFT_A2, ZC_TOP, 5'd30, 1'b0, 3, 1'b0);
    queue_word(ZC_SHIFT_A1, ZC_SHIFT_A2, ZC_LITERAL, 1'b1, 1, 1'b0);
    queue_word(ZC_TOP, ZC_TOP, 5'd6, 1'b0, 1, 1'b0);
    queue_word(ZC_SHIFT_A2, ZC_LITERAL, ZC_SPACE, 1'b0, 0, 1'b0);
    queue_word(ZC_SPACE, 5'd6, 5'd6, 1'b1, 0, 1'b0);
    queue_word(5'd6, 5'd6, 5'd6, 1'b1, 0, 1'b0);
    queue_word(ZC_TOP, ZC_TOP, ZC_TOP, 1'b1, 0, 1'b0);
    queue_word(ZC_SPACE, ZC_SPACE, ZC_SPACE, 1'b0, 2, 1'b1);
    drain();

    // tiny buffer: fill, dropped request, top address carry
    apply_settings(16'hFFFF, 16'd4);
    queue_word(5'd6, 5'd7, 5'd8, 1'b0, 0, 1'b1);
    queue_word(ZC_BANK1, ZC_SHIFT_A1, 5'd6, 1'b0, 0, 1'b0);
    queue_word(ZC_SPACE, ZC_SPACE, ZC_SPACE, 1'b1, 0, 1'b0);
    queue_word(ZC_BANK3, ZC_TOP, 5'd6, 1'b0, 0, 1'b1);
    queue_word(5'd6, 5'd6, 5'd6, 1'b1, 0, 1'b0);
    drain();

    // no usable slot
    apply_settings(16'h0000, 16'd1);
    queue_word(5'd6, 5'd6, 5'd6, 1'b1, 0, 1'b1);
    queue_word(5'd6, 5'd6, 5'd6, 1'b0, 1, 1'b1);
    drain();
    apply_settings(16'($urandom), 16'd0);
    queue_word(ZC_BANK1, ZC_SPACE, 5'd6, 1'b0, 0, 1'b1);
    drain();

    start = queued;
    phase = 0;
    while (queued - start < RANDOM_WORDS) begin
      case (phase % 7)
        0: apply_settings(16'($urandom), 16'd256);
        1: apply_settings(16'h0000, 16'd10);
        2: apply_settings(16'hFFFF, 16'd4096);
        3: apply_settings(16'($urandom), 16'd8191);
        4: apply_settings(16'($urandom), 16'd0);
        5: apply_settings(16'($urandom), 16'd2);
        default: apply_settings(16'($urandom), {3'b111, 13'($urandom_range(1, 40))});
      endcase
      pick_idling();
      target = queued + 55;
      while (queued < target) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          queue_string(0, $urandom_range(2, 16), 1'b1, 1'b1);
        end else if (r < 88) begin
          queue_string(0, $urandom_range(1, 10), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end else begin
          w = 16'($urandom);
          queue_word(w[14:10], w[9:5], w[4:0], w[15], $urandom_range(0, 3),
                     1'($urandom_range(0, 1)));
        end
      end
      drain();
      phase++;
    end

    // closing stretch at full rate
    calm = 1'b1;
    idle_pct = 0;
    apply_settings(16'($urandom), 16'd256);
    target = queued + 40;
    while (queued < target) queue_string(0, $urandom_range(2, 16), 1'b1, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("zstring_text_decoder regression: pass");
    end else begin
      $display("zstring_text_decoder regression: fail");
    end
    $finish;
  end

endmodule
